// ===== hw/rtl/rpn_stack_interpreter_stream_core_macros.svh =====
// Assertion macros shared by the stack interpreter RTL.
// RPN_ASSERT expects signals named clk and rst_n in the using module; RPN_ASSERT_ALWAYS needs only clk.
`ifndef RPN_STACK_INTERPRETER_STREAM_CORE_MACROS_SVH
`define RPN_STACK_INTERPRETER_STREAM_CORE_MACROS_SVH
`ifndef SYNTH
`define RPN_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rpn assertion failed");
`define RPN_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("rpn assertion failed");
`else
`define RPN_ASSERT(lbl, prop)
`define RPN_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== hw/rtl/rpn_pkg.sv =====
// Types and constants of the stack interpreter.
// No dependencies; used by the core, rpn_alu and the bench.
package rpn_pkg;

  typedef struct packed {
    logic [7:0]         code_byte;
    logic signed [31:0] entered_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] number;
    logic [7:0]         text_char;
  } out_item_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV,
    ALU_REM
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } alu_rsp_t;

  localparam logic [2:0] KIND_NUMBER    = 3'd0;
  localparam logic [2:0] KIND_TEXT      = 3'd1;
  localparam logic [2:0] KIND_NEWLINE   = 3'd2;
  localparam logic [2:0] KIND_UNDERFLOW = 3'd3;
  localparam logic [2:0] KIND_DIVZERO   = 3'd4;
  localparam logic [2:0] KIND_END       = 3'd5;

  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_QUOTE  = 2'd1;
  localparam logic [1:0] MODE_CMT_N  = 2'd2;
  localparam logic [1:0] MODE_CMT_Q  = 2'd3;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_QUERY  = 8'h3F;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

endpackage

// ===== hw/rtl/rpn_stack_interpreter_stream_core.sv =====
// Streaming postfix stack interpreter: one program byte per input item, at
// most one result item per byte. The input stalls while an item is worked on.
// Digits, a tilde in normal mode, bytes in comments, and a quote or tilde in
// quotes finish in S_IDLE, so such items can arrive every cycle; an echoed
// quoted character also passes S_OUT, any other byte in normal mode S_EXEC.
// An operator first pushes any pending number, then reads its operands from
// the stack memory one per cycle; / and % use the shared divider, which
// produces one quotient bit per cycle. A byte that yields a result hands it
// from S_OUT to the output register, waiting while the register is full and stalled.
// After an underflow, a divide by zero or the end marker the block ignores all
// items until reset. Depends on rpn_pkg, rpn_stack, rpn_alu and macro header.
`include "rpn_stack_interpreter_stream_core_macros.svh"
module rpn_stack_interpreter_stream_core
  import rpn_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDA,
    S_RDW,
    S_ALU,
    S_PRD,
    S_OUT
  } state_t;

  state_t      state_r;
  logic [CW-1:0] cnt_r;
  logic [31:0] acc_r;
  logic        pend_r;
  logic [1:0]  mode_r;
  logic        halted_r;
  logic [7:0]  op_r;
  logic [31:0] ent_r;
  logic [31:0] b_r;
  out_item_t   res_r;
  logic        out_valid_r;
  out_item_t   out_data_r;

  logic          in_fire;
  logic          out_load;
  logic [7:0]    c;
  logic          is_digit;
  logic          room;
  logic          push_pend;
  logic          div_like;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;

  function automatic out_item_t mk_out(logic [2:0] kind, logic [31:0] num,
                                       logic [7:0] ch);
    out_item_t o;
    o.kind      = kind;
    o.number    = $signed(num);
    o.text_char = ch;
    return o;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign c         = in_data.code_byte;
  assign is_digit  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign room      = (cnt_r < CW'(STACK_DEPTH));
  assign cnt_m1    = cnt_r - CW'(1);
  assign cnt_m2    = cnt_r - CW'(2);
  assign div_like  = (op_r == CH_SLASH) || (op_r == CH_PCT);
  assign push_pend = in_fire && !halted_r && (mode_r == MODE_NORMAL) && !is_digit
                     && (c != CH_TILDE) && pend_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r[AW-1:0];
    mem_wdata = acc_r;
    if (push_pend) begin
      mem_we = room;
    end else if ((state_r == S_EXEC) && (op_r == CH_QUERY)) begin
      mem_we    = room;
      mem_wdata = ent_r;
    end else if ((state_r == S_ALU) && alu_rsp.done) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_m2[AW-1:0];
      mem_wdata = alu_rsp.value;
    end
    mem_raddr = (state_r == S_RDA) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
  end

  always_comb begin
    alu_req.start = (state_r == S_RDW) && !(div_like && (b_r == 32'd0));
    case (op_r)
      CH_MINUS: alu_req.op = ALU_SUB;
      CH_STAR:  alu_req.op = ALU_MUL;
      CH_SLASH: alu_req.op = ALU_DIV;
      CH_PCT:   alu_req.op = ALU_REM;
      default:  alu_req.op = ALU_ADD;
    endcase
  end

  rpn_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rpn_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .a     (mem_rdata),
    .b     (b_r),
    .rsp   (alu_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      acc_r       <= '0;
      pend_r      <= 1'b0;
      mode_r      <= MODE_NORMAL;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire && !halted_r) begin
            if (mode_r[1]) begin
              if (c == CH_NL) begin
                mode_r <= {1'b0, mode_r[0]};
              end
            end else if (mode_r == MODE_QUOTE) begin
              if (c == CH_QUOTE) begin
                mode_r <= MODE_NORMAL;
              end else if (c == CH_TILDE) begin
                mode_r <= MODE_CMT_Q;
              end else if (c == CH_BANG) begin
                res_r   <= mk_out(KIND_NEWLINE, 32'd0, 8'd0);
                state_r <= S_OUT;
              end else begin
                res_r   <= mk_out(KIND_TEXT, 32'd0, c);
                state_r <= S_OUT;
              end
            end else if (is_digit) begin
              acc_r  <= (acc_r << 3) + (acc_r << 1) + {28'd0, c[3:0]};
              pend_r <= 1'b1;
            end else if (c == CH_TILDE) begin
              mode_r <= MODE_CMT_N;
            end else begin
              if (pend_r) begin
                acc_r  <= '0;
                pend_r <= 1'b0;
                if (room) begin
                  cnt_r <= cnt_r + CW'(1);
                end
              end
              op_r    <= c;
              ent_r   <= in_data.entered_value;
              state_r <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          unique case (op_r) inside
            CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: begin
              if (cnt_r < CW'(2)) begin
                res_r    <= mk_out(KIND_UNDERFLOW, 32'd0, 8'd0);
                halted_r <= 1'b1;
                state_r  <= S_OUT;
              end else begin
                state_r <= S_RDA;
              end
            end
            CH_BANG: begin
              if (cnt_r == '0) begin
                res_r    <= mk_out(KIND_UNDERFLOW, 32'd0, 8'd0);
                halted_r <= 1'b1;
                state_r  <= S_OUT;
              end else begin
                cnt_r   <= cnt_m1;
                state_r <= S_PRD;
              end
            end
            CH_QUERY: begin
              if (room) begin
                cnt_r <= cnt_r + CW'(1);
              end
              state_r <= S_IDLE;
            end
            CH_QUOTE: begin
              mode_r  <= MODE_QUOTE;
              state_r <= S_IDLE;
            end
            CH_DOLLAR: begin
              res_r    <= mk_out(KIND_END, 32'd0, 8'd0);
              halted_r <= 1'b1;
              state_r  <= S_OUT;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_RDA: begin
          b_r     <= mem_rdata;
          state_r <= S_RDW;
        end
        S_RDW: begin
          if (div_like && (b_r == 32'd0)) begin
            res_r    <= mk_out(KIND_DIVZERO, 32'd0, 8'd0);
            halted_r <= 1'b1;
            state_r  <= S_OUT;
          end else begin
            state_r <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_rsp.done) begin
            cnt_r   <= cnt_m1;
            state_r <= S_IDLE;
          end
        end
        S_PRD: begin
          res_r   <= mk_out(KIND_NUMBER, mem_rdata, 8'd0);
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            out_data_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RPN_ASSERT(a_cnt_bound, cnt_r <= CW'(STACK_DEPTH))
  `RPN_ASSERT(a_halt_sticky, halted_r |=> halted_r)
  `RPN_ASSERT(a_alu_done_in_wait, alu_rsp.done |-> state_r == S_ALU)

endmodule

// ===== hw/rtl/rpn_stack.sv =====
// Operand stack storage: one write port and one registered read port.
// Depends on nothing but its DEPTH parameter.
module rpn_stack #(
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem_r [DEPTH];
  logic [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/rpn_alu.sv =====
// Shared arithmetic unit: add, subtract, multiply without leaving idle, and signed
// divide or remainder by a restoring divider, one quotient bit per cycle.
// Depends on rpn_pkg and the assertion macros.
`include "rpn_stack_interpreter_stream_core_macros.svh"
module rpn_alu
  import rpn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  alu_req_t    req,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output alu_rsp_t    rsp
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_DIV,
    A_FIX
  } alu_state_t;

  alu_state_t  ast_r;
  alu_op_t     op_r;
  logic [31:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] mb_r;
  logic [4:0]  cnt_r;
  logic        an_r;
  logic        neg_r;
  logic [31:0] val_r;
  logic        done_r;

  logic [32:0] rem_sh;
  logic [32:0] diff;
  logic        fits;
  logic [31:0] ma;
  logic [31:0] mb;

  assign ma     = a[31] ? (32'd0 - a) : a;
  assign mb     = b[31] ? (32'd0 - b) : b;
  assign rem_sh = {rem_r, quo_r[31]};
  assign diff   = rem_sh - {1'b0, mb_r};
  assign fits   = !diff[32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ast_r  <= A_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ast_r)
        A_IDLE: begin
          if (req.start) begin
            op_r <= req.op;
            unique case (req.op) inside
              ALU_ADD: begin
                val_r  <= a + b;
                done_r <= 1'b1;
              end
              ALU_SUB: begin
                val_r  <= a - b;
                done_r <= 1'b1;
              end
              ALU_MUL: begin
                val_r  <= a * b;
                done_r <= 1'b1;
              end
              ALU_DIV, ALU_REM: begin
                quo_r <= ma;
                rem_r <= '0;
                mb_r  <= mb;
                cnt_r <= 5'd31;
                an_r  <= a[31];
                neg_r <= a[31] ^ b[31];
                ast_r <= A_DIV;
              end
              default: begin
                val_r  <= '0;
                done_r <= 1'b1;
              end
            endcase
          end
        end
        A_DIV: begin
          rem_r <= fits ? diff[31:0] : rem_sh[31:0];
          quo_r <= {quo_r[30:0], fits};
          cnt_r <= cnt_r - 5'd1;
          if (cnt_r == 5'd0) begin
            ast_r <= A_FIX;
          end
        end
        A_FIX: begin
          if (op_r == ALU_DIV) begin
            val_r <= neg_r ? (32'd0 - quo_r) : quo_r;
          end else begin
            val_r <= an_r ? (32'd0 - rem_r) : rem_r;
          end
          done_r <= 1'b1;
          ast_r  <= A_IDLE;
        end
        default: ast_r <= A_IDLE;
      endcase
    end
  end

  assign rsp.done  = done_r;
  assign rsp.value = val_r;

  `RPN_ASSERT(a_start_when_idle, req.start |-> ast_r == A_IDLE)
  `RPN_ASSERT(a_done_single, rsp.done |=> !rsp.done)
  `RPN_ASSERT(a_busy_is_div, (ast_r != A_IDLE) |-> (op_r == ALU_DIV) || (op_r == ALU_REM))

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for rpn_stack_interpreter_stream_core: feeds program bytes, predicts
// every printed number, echoed character and error with an in-bench interpreter.
// Depends on rpn_pkg and the core RTL.
module tb_top
  import rpn_pkg::*;
();

  localparam int          DEPTH         = 32;
  localparam int unsigned RANDOM_ITEMS  = 720;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned DRAIN_CYCLES  = 20000;
  localparam int unsigned TIMEOUT_NS    = 5_000_000;
  localparam logic [7:0]  CH_SPACE      = 8'h20;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  logic [31:0] operands [DEPTH];
  int unsigned operand_count;
  logic [31:0] digit_acc;
  bit          digit_pending;
  logic [1:0]  lex_mode;
  bit          run_halted;

  out_item_t   predicted_outputs [$];
  int unsigned err_count;
  int unsigned prog_sent;
  int unsigned hold_reqs;
  int unsigned holds_seen;
  bit          send_gaps;

  rpn_stack_interpreter_stream_core #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

  task automatic flag_error(input string msg);
    if (err_count < 40) $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 90);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'($urandom_range(1, 20));
      5: return -32'($urandom_range(1, 20));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] rand_operator();
    case ($urandom_range(0, 4))
      0: return CH_PLUS;
      1: return CH_MINUS;
      2: return CH_STAR;
      3: return CH_SLASH;
      default: return CH_PCT;
    endcase
  endfunction

  function automatic void push_operand(input logic [31:0] v);
    if (operand_count < DEPTH) begin
      operands[operand_count] = v;
      operand_count++;
    end
  endfunction

  function automatic out_item_t halt_item(input logic [2:0] kind);
    out_item_t r;
    r = '0;
    r.kind = kind;
    run_halted = 1'b1;
    return r;
  endfunction

  function automatic bit interpret_byte(input in_item_t it, output out_item_t r);
    logic [7:0]  c;
    logic [31:0] a, b, ma, mb, q, v;
    c = it.code_byte;
    r = '0;
    if (run_halted) return 1'b0;
    if (lex_mode == MODE_CMT_N || lex_mode == MODE_CMT_Q) begin
      if (c == CH_NL) lex_mode = (lex_mode == MODE_CMT_N) ? MODE_NORMAL : MODE_QUOTE;
      return 1'b0;
    end
    if (lex_mode == MODE_QUOTE) begin
      if (c == CH_QUOTE) begin
        lex_mode = MODE_NORMAL;
        return 1'b0;
      end
      if (c == CH_TILDE) begin
        lex_mode = MODE_CMT_Q;
        return 1'b0;
      end
      r.kind = (c == CH_BANG) ? KIND_NEWLINE : KIND_TEXT;
      r.text_char = (c == CH_BANG) ? 8'h00 : c;
      return 1'b1;
    end
    if (c >= CH_ZERO && c <= CH_NINE) begin
      digit_acc = digit_acc * 32'd10 + 32'(c - CH_ZERO);
      digit_pending = 1'b1;
      return 1'b0;
    end
    if (c == CH_TILDE) begin
      lex_mode = MODE_CMT_N;
      return 1'b0;
    end
    if (digit_pending) begin
      push_operand(digit_acc);
      digit_acc = '0;
      digit_pending = 1'b0;
    end
    case (c)
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_PCT: begin
        if (operand_count < 2) begin
          r = halt_item(KIND_UNDERFLOW);
          return 1'b1;
        end
        b = operands[operand_count - 1];
        a = operands[operand_count - 2];
        if ((c == CH_SLASH || c == CH_PCT) && b == 32'd0) begin
          r = halt_item(KIND_DIVZERO);
          return 1'b1;
        end
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        case (c)
          CH_PLUS:  v = a + b;
          CH_MINUS: v = a - b;
          CH_STAR:  v = a * b;
          CH_SLASH: begin
            q = ma / mb;
            v = (a[31] != b[31]) ? -q : q;
          end
          default: begin
            q = ma % mb;
            v = a[31] ? -q : q;
          end
        endcase
        operand_count -= 2;
        push_operand(v);
      end
      CH_BANG: begin
        if (operand_count == 0) begin
          r = halt_item(KIND_UNDERFLOW);
          return 1'b1;
        end
        operand_count--;
        r.kind = KIND_NUMBER;
        r.number = operands[operand_count];
        return 1'b1;
      end
      CH_QUERY:  push_operand(it.entered_value);
      CH_QUOTE:  lex_mode = MODE_QUOTE;
      CH_DOLLAR: begin
        r = halt_item(KIND_END);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic bit byte_would_halt(input logic [7:0] c);
    logic [31:0] mem_keep [DEPTH];
    int unsigned cnt_keep;
    logic [31:0] acc_keep;
    bit          pend_keep;
    logic [1:0]  mode_keep;
    bit          halted_keep;
    bit          halts;
    in_item_t    probe;
    out_item_t   ignored;
    mem_keep = operands;
    cnt_keep = operand_count;
    acc_keep = digit_acc;
    pend_keep = digit_pending;
    mode_keep = lex_mode;
    halted_keep = run_halted;
    probe = '0;
    probe.code_byte = c;
    void'(interpret_byte(probe, ignored));
    halts = run_halted && !halted_keep;
    operands = mem_keep;
    operand_count = cnt_keep;
    digit_acc = acc_keep;
    digit_pending = pend_keep;
    lex_mode = mode_keep;
    run_halted = halted_keep;
    return halts;
  endfunction

  task automatic send_byte(input logic [7:0] c, input logic [31:0] v);
    in_item_t    it;
    out_item_t   res;
    int unsigned gap;
    it.code_byte = c;
    it.entered_value = v;
    gap = send_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (interpret_byte(it, res)) predicted_outputs.push_back(res);
  endtask

  task automatic send_prog(input logic [7:0] c);
    logic [7:0] b;
    b = c;
    if (lex_mode == MODE_NORMAL && byte_would_halt(b)) b = CH_SPACE;
    if (!run_halted && lex_mode < MODE_CMT_N) prog_sent++;
    send_byte(b, pick_value());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (predicted_outputs.size() != 0);
  endtask

  task automatic send_comment_body();
    logic [7:0] c;
    send_prog(CH_TILDE);
    repeat ($urandom_range(0, 6)) begin
      c = 8'($urandom_range(0, 255));
      if (c == CH_NL) c = CH_SPACE;
      send_prog(c);
    end
    send_prog(CH_NL);
  endtask

  task automatic send_fragment();
    int unsigned r;
    logic [7:0]  c;
    r = $urandom_range(0, 99);
    if (r < 28) begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 3))
        send_prog(CH_ZERO + 8'($urandom_range(0, 9)));
    end else if (r < 42) begin
      send_prog(CH_QUERY);
    end else if (r < 60) begin
      send_prog(rand_operator());
    end else if (r < 70) begin
      send_prog(CH_BANG);
    end else if (r < 78) begin
      send_prog(CH_QUOTE);
      repeat ($urandom_range(0, 10)) begin
        case ($urandom_range(0, 9))
          0: send_prog(CH_BANG);
          1: send_comment_body();
          2: send_prog(CH_NL);
          default: begin
            c = 8'($urandom_range(0, 255));
            send_prog(c);
          end
        endcase
      end
      send_prog(CH_QUOTE);
    end else if (r < 84) begin
      send_comment_body();
    end else if (r < 92) begin
      send_prog($urandom_range(0, 1) ? CH_SPACE : 8'($urandom_range(0, 255)));
    end else if (r < 95) begin
      repeat (DEPTH - operand_count + $urandom_range(1, 3)) send_prog(CH_QUERY);
      repeat ($urandom_range(DEPTH - 4, DEPTH)) send_prog(CH_BANG);
    end else begin
      send_prog(CH_SPACE);
    end
  endtask

  task automatic test_arith_extremes();
    send_byte(CH_QUERY, 32'h7FFF_FFFF);
    send_byte(CH_QUERY, 32'h0000_0001);
    send_byte(CH_PLUS, pick_value());
    send_byte(CH_QUERY, 32'hFFFF_FFFF);
    send_byte(CH_SLASH, pick_value());
    send_byte(CH_QUERY, 32'hFFFF_FFFF);
    send_byte(CH_STAR, pick_value());
    send_byte(CH_QUERY, 32'h0000_0003);
    send_byte(CH_MINUS, pick_value());
    send_byte(CH_QUERY, 32'hFFFF_FFFE);
    send_byte(CH_PCT, pick_value());
    send_byte(CH_BANG, pick_value());
  endtask

  task automatic test_digit_runs();
    string digits;
    digits = "4294967297";
    foreach (digits[i]) send_byte(digits[i], pick_value());
    send_byte(CH_TILDE, pick_value());
    send_byte(CH_NL, pick_value());
    send_byte(CH_ZERO + 8'd5, pick_value());
    send_byte(CH_BANG, pick_value());
  endtask

  task automatic test_quoted_text();
    send_byte(CH_QUOTE, pick_value());
    send_byte(8'h00, pick_value());
    send_byte(8'hFF, pick_value());
    send_byte(CH_BANG, pick_value());
    send_byte(CH_TILDE, pick_value());
    send_byte(CH_DOLLAR, pick_value());
    send_byte(CH_NL, pick_value());
    send_byte(CH_DOLLAR, pick_value());
    send_byte(CH_QUOTE, pick_value());
  endtask

  task automatic test_output_backpressure();
    send_gaps = 1'b0;
    hold_reqs <= hold_reqs + 1;
    send_byte(CH_QUOTE, pick_value());
    repeat (48) send_byte(8'($urandom_range(8'h41, 8'h5A)), pick_value());
    send_byte(CH_QUOTE, pick_value());
    send_gaps = 1'b1;
    wait_drained();
  endtask

  task automatic test_random_programs(input int unsigned count);
    int unsigned target;
    target = prog_sent + count;
    while (prog_sent < target) send_fragment();
  endtask

  task automatic test_halt_and_ignore();
    while (lex_mode != MODE_NORMAL)
      send_byte((lex_mode == MODE_QUOTE) ? CH_QUOTE : CH_NL, pick_value());
    case ($urandom_range(0, 2))
      0: send_byte(CH_DOLLAR, pick_value());
      1: begin
        while (operand_count > DEPTH - 2 || digit_pending) send_byte(CH_BANG, pick_value());
        send_byte(CH_QUERY, pick_value());
        send_byte(CH_QUERY, 32'h0);
        send_byte($urandom_range(0, 1) ? CH_SLASH : CH_PCT, pick_value());
      end
      default: begin
        while (operand_count != 0 || digit_pending) send_byte(CH_BANG, pick_value());
        if ($urandom_range(0, 1)) begin
          send_byte(CH_QUERY, 32'h0);
          send_byte(rand_operator(), pick_value());
        end else begin
          send_byte(CH_BANG, pick_value());
        end
      end
    endcase
    repeat (24) send_byte(8'($urandom_range(0, 255)), $urandom);
  endtask

  initial begin : result_stall_gen
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen = hold_reqs;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && run_left == 0) begin
        stall_left = pick_gap();
        run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 4);
      end
      if (stall_left != 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        if (run_left != 0) run_left--;
      end
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (predicted_outputs.size() == 0) begin
        flag_error($sformatf("unexpected result kind %0d", out_data.kind));
      end else begin
        want = predicted_outputs.pop_front();
        if (out_data.kind !== want.kind)
          flag_error($sformatf("kind %0d, expected %0d", out_data.kind, want.kind));
        if (out_data.number !== want.number)
          flag_error($sformatf("number %0d, expected %0d", out_data.number, want.number));
        if (out_data.text_char !== want.text_char)
          flag_error($sformatf("char %h, expected %h", out_data.text_char, want.text_char));
      end
    end
  end

  initial begin
    int unsigned waited;
    foreach (operands[i]) operands[i] = '0;
    operand_count = 0;
    digit_acc = '0;
    digit_pending = 1'b0;
    lex_mode = MODE_NORMAL;
    run_halted = 1'b0;
    err_count = 0;
    prog_sent = 0;
    hold_reqs = 0;
    holds_seen = 0;
    send_gaps = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_arith_extremes();
    test_digit_runs();
    test_quoted_text();
    test_output_backpressure();
    for (int batch = 0; batch < 4; batch++) begin
      send_gaps = (batch != 1);
      test_random_programs(RANDOM_ITEMS / 4);
      wait_drained();
    end
    send_gaps = 1'b1;
    test_halt_and_ignore();

    in_valid <= 1'b0;
    waited = 0;
    while (predicted_outputs.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_outputs.size() != 0)
      flag_error($sformatf("%0d results never arrived", predicted_outputs.size()));
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/rpn_pkg.sv
hw/rtl/rpn_stack.sv
hw/rtl/rpn_alu.sv
hw/rtl/rpn_stack_interpreter_stream_core.sv
tb/sv/tb_top.sv
